// ===== src/bcdma_pkg.sv =====
// Shared types and constants for the byte copy DMA with memory.
`default_nettype none

package bcdma_pkg;

    // Default memory size in bytes
    localparam int MEMORY_BYTES_DEFAULT = 256;

    // Operation codes carried by an input word
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_COPY  = 2'd2
    } op_t;

    // Input word
    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] byte_address;
        logic [7:0]  write_byte;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic [7:0] read_byte;
        logic       address_error;
    } out_word_t;

endpackage

`default_nettype wire

// ===== src/bcdma_addr_unit.sv =====
// Shared address adder and range check used by single accesses and copies.
`default_nettype none

module bcdma_addr_unit
    import bcdma_pkg::*;
#(
    parameter int MEMORY_BYTES = MEMORY_BYTES_DEFAULT
)(
    input  wire logic [15:0] base,
    input  wire logic [15:0] offset,
    output logic      [16:0] sum,
    output logic             out_of_range
);

    // Sum without wrap, then compare against the memory size
    always_comb
    begin
        sum          = {1'b0, base} + {1'b0, offset};
        out_of_range = (sum >= 17'(MEMORY_BYTES));
    end

endmodule

`default_nettype wire

// ===== src/byte_copy_dma_with_memory_unit.sv =====
// Top level: byte memory, single byte access and forward DMA copy sequencer.
// An in-range read passes through ST_READ and a copy through ST_COPY_RD and ST_COPY_WR
// for each byte before ST_FINISH loads the result; one word is in flight at a time:
// in_ready is low from accept until the result is loaded, longer under output stalls.
// After rst_n deasserts a clearing pass zeroes the memory; no word is accepted during it,
// configuration writes are taken as usual.
`default_nettype none

module byte_copy_dma_with_memory_unit
    import bcdma_pkg::*;
#(
    parameter int MEMORY_BYTES = MEMORY_BYTES_DEFAULT
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // APB configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // Input channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire in_word_t    in_word,
    // Result channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output out_word_t        out_word
);

    localparam int AW = $clog2(MEMORY_BYTES);

    // Register indexes
    localparam logic [1:0] REG_SRC = 2'd0;
    localparam logic [1:0] REG_DST = 2'd1;
    localparam logic [1:0] REG_CNT = 2'd2;

    typedef enum logic [5:0] {
        ST_CLEAR   = 6'b000001,
        ST_IDLE    = 6'b000010,
        ST_READ    = 6'b000100,
        ST_COPY_RD = 6'b001000,
        ST_COPY_WR = 6'b010000,
        ST_FINISH  = 6'b100000
    } state_t;

    state_t      state_reg, state_next;
    logic [15:0] src_reg, dst_reg, cnt_reg;
    logic [15:0] idx_reg, idx_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [7:0]  held_reg, held_next;
    logic        rd_ok_reg, rd_ok_next;
    logic [7:0]  res_rd_reg, res_rd_next;
    logic        res_err_reg, res_err_next;
    logic        out_valid_reg, out_valid_next;
    out_word_t   out_word_reg, out_word_next;

    logic [7:0]  mem [MEMORY_BYTES];
    logic [7:0]  mem_rdata_reg;
    logic        mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]  mem_wdata;
    logic [7:0]  copy_byte;

    logic [15:0] au_base, au_offset;
    logic [16:0] au_sum;
    logic        au_oor;
    logic        cfg_write;
    logic        in_accept;

    // Configuration registers
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg <= '0;
            dst_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_SRC: src_reg <= pwdata[15:0];
                REG_DST: dst_reg <= pwdata[15:0];
                REG_CNT: cnt_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_SRC: prdata = {16'd0, src_reg};
            REG_DST: prdata = {16'd0, dst_reg};
            REG_CNT: prdata = {16'd0, cnt_reg};
            default: prdata = '0;
        endcase
    end

    // Shared address unit: base selected by the sequencer step
    always_comb
    begin
        case (state_reg)
            ST_COPY_RD:
            begin
                au_base   = src_reg;
                au_offset = idx_reg;
            end
            ST_COPY_WR:
            begin
                au_base   = dst_reg;
                au_offset = idx_reg;
            end
            default:
            begin
                au_base   = in_word.byte_address;
                au_offset = '0;
            end
        endcase
    end

    bcdma_addr_unit #(
        .MEMORY_BYTES (MEMORY_BYTES)
    ) u_addr (
        .base         (au_base),
        .offset       (au_offset),
        .sum          (au_sum),
        .out_of_range (au_oor)
    );

    // Handshake
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // Byte that a copy writes: fresh read data, or the held byte after a refused read
    assign copy_byte = rd_ok_reg ? mem_rdata_reg : held_reg;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        clr_next       = clr_reg;
        held_next      = held_reg;
        rd_ok_next     = rd_ok_reg;
        res_rd_next    = res_rd_reg;
        res_err_next   = res_err_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_word_next  = out_word_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(MEMORY_BYTES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    res_rd_next  = '0;
                    res_err_next = 1'b0;
                    idx_next     = '0;
                    state_next   = ST_FINISH;
                    case (in_word.operation)
                        OP_WRITE:
                        begin
                            if (au_oor)
                            begin
                                res_err_next = 1'b1;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = au_sum[AW-1:0];
                                mem_wdata = in_word.write_byte;
                            end
                        end
                        OP_READ:
                        begin
                            if (au_oor)
                            begin
                                res_err_next = 1'b1;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = au_sum[AW-1:0];
                                state_next = ST_READ;
                            end
                        end
                        OP_COPY:
                        begin
                            if (cnt_reg != '0)
                            begin
                                state_next = ST_COPY_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ:
            begin
                res_rd_next = mem_rdata_reg;
                state_next  = ST_FINISH;
            end
            ST_COPY_RD:
            begin
                if (au_oor)
                begin
                    res_err_next = 1'b1;
                    rd_ok_next   = 1'b0;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = au_sum[AW-1:0];
                    rd_ok_next = 1'b1;
                end
                state_next = ST_COPY_WR;
            end
            ST_COPY_WR:
            begin
                held_next = copy_byte;
                if (au_oor)
                begin
                    res_err_next = 1'b1;
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_waddr = au_sum[AW-1:0];
                    mem_wdata = copy_byte;
                end
                idx_next = idx_reg + 16'd1;
                if (idx_reg == cnt_reg - 16'd1)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_COPY_RD;
                end
            end
            ST_FINISH:
            begin
                // Load the result once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next              = 1'b1;
                    out_word_next.read_byte     = res_rd_reg;
                    out_word_next.address_error = res_err_reg;
                    state_next                  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            idx_reg       <= '0;
            clr_reg       <= '0;
            held_reg      <= '0;
            rd_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            clr_reg       <= clr_next;
            held_reg      <= held_next;
            rd_ok_reg     <= rd_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        res_rd_reg   <= res_rd_next;
        res_err_reg  <= res_err_next;
        out_word_reg <= out_word_next;
    end

    // Byte memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/bcdma_checker.sv =====
// Port-level checks for the byte copy DMA, bound to the top level.
`default_nettype none

module bcdma_checker
    import bcdma_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_valid,
    input wire logic      in_ready,
    input wire in_word_t  in_word,
    input wire logic      out_valid,
    input wire logic      out_ready,
    input wire out_word_t out_word
);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("result changed while stalled");

    // Every accepted word makes the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted on back-to-back cycles");

    // A result appears only after the block has been busy
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result without preceding work");

    // A refused access never returns data
    a_error_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.address_error |-> out_word.read_byte == 8'd0)
        else $error("data returned with an address error");

endmodule

bind byte_copy_dma_with_memory_unit bcdma_checker u_bcdma_checker (.*);

`default_nettype wire
